// File: design/conv2d_clamp_edge_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for conv2d_clamp_edge_core
// Clocked, reset-gated implication checks shared by the checker.
// ----------------------------------------------------------------------------
`ifndef CONV2D_CLAMP_EDGE_CORE_MACROS_SVH
`define CONV2D_CLAMP_EDGE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define C2CE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("c2ce check failed");

// Next-cycle implication, disabled while reset is low.
`define C2CE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("c2ce check failed");

`endif

// File: design/c2ce_pkg.sv
// ----------------------------------------------------------------------------
// c2ce_pkg
// Shared sizes, codes and types of the clamp-to-edge convolution core.
// ----------------------------------------------------------------------------
package c2ce_pkg;

    localparam int MAX_HEIGHT = 256;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_KERNEL = 7;

    localparam int FRAME_DEPTH = MAX_HEIGHT * MAX_WIDTH;
    localparam int COEFF_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int FA_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int CA_W = (COEFF_DEPTH > 1) ? $clog2(COEFF_DEPTH) : 1;

    localparam int PIX_W   = 16;
    localparam int COEFF_W = 18;
    localparam int PROD_W  = PIX_W + COEFF_W;
    localparam int ACC_W   = 40;

    // operation codes
    localparam logic [1:0] OP_LOAD_COEFF = 2'd0;
    localparam logic [1:0] OP_LOAD_PIXEL = 2'd1;
    localparam logic [1:0] OP_COMPUTE    = 2'd2;

    // register indexes
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd2;
    localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd3;
    localparam logic [2:0] REG_SAME_SIZE     = 3'd4;

    typedef struct packed {
        logic [8:0] image_height;
        logic [8:0] image_width;
        logic [2:0] kernel_height;
        logic [2:0] kernel_width;
        logic       same_size;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic issue;
    } t_mac_ctl;

endpackage

// File: design/c2ce_store.sv
// ----------------------------------------------------------------------------
// c2ce_store
// Frame store and coefficient store, one write and one registered read each.
// ----------------------------------------------------------------------------
module c2ce_store (
    input  logic                             i_clk,
    input  logic                             i_frame_we,
    input  logic [c2ce_pkg::FA_W-1:0]        i_frame_waddr,
    input  logic signed [c2ce_pkg::PIX_W-1:0]   i_frame_wdata,
    input  logic                             i_coeff_we,
    input  logic [c2ce_pkg::CA_W-1:0]        i_coeff_waddr,
    input  logic signed [c2ce_pkg::COEFF_W-1:0] i_coeff_wdata,
    input  logic                             i_rd_en,
    input  logic [c2ce_pkg::FA_W-1:0]        i_frame_raddr,
    input  logic [c2ce_pkg::CA_W-1:0]        i_coeff_raddr,
    output logic signed [c2ce_pkg::PIX_W-1:0]   o_pixel,
    output logic signed [c2ce_pkg::COEFF_W-1:0] o_coeff
);

    logic signed [c2ce_pkg::PIX_W-1:0]   r_frame_mem [c2ce_pkg::FRAME_DEPTH];
    logic signed [c2ce_pkg::COEFF_W-1:0] r_coeff_mem [c2ce_pkg::COEFF_DEPTH];
    logic signed [c2ce_pkg::PIX_W-1:0]   r_pixel;
    logic signed [c2ce_pkg::COEFF_W-1:0] r_coeff;

    always_ff @(posedge i_clk) begin
        if (i_frame_we) begin
            r_frame_mem[i_frame_waddr] <= i_frame_wdata;
        end
        if (i_rd_en) begin
            r_pixel <= r_frame_mem[i_frame_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_coeff_we) begin
            r_coeff_mem[i_coeff_waddr] <= i_coeff_wdata;
        end
        if (i_rd_en) begin
            r_coeff <= r_coeff_mem[i_coeff_raddr];
        end
    end

    assign o_pixel = r_pixel;
    assign o_coeff = r_coeff;

endmodule

// File: design/c2ce_mac.sv
// ----------------------------------------------------------------------------
// c2ce_mac
// Shared multiply-accumulate unit: registered product, then 40-bit sum.
// ----------------------------------------------------------------------------
module c2ce_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  c2ce_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [c2ce_pkg::PIX_W-1:0]   i_pixel,
    input  logic signed [c2ce_pkg::COEFF_W-1:0] i_coeff,
    output logic signed [c2ce_pkg::ACC_W-1:0]   o_acc,
    output logic                                o_pipe_busy
);

    logic                                r_v1;
    logic                                r_v2;
    logic signed [c2ce_pkg::PROD_W-1:0]  r_prod;
    logic signed [c2ce_pkg::ACC_W-1:0]   r_acc;
    logic signed [c2ce_pkg::ACC_W-1:0]   n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (r_v2) begin
            n_acc = r_acc + c2ce_pkg::ACC_W'(r_prod);
        end
    end

    // valid tags follow the store read and the product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_pixel * i_coeff;
        r_acc  <= n_acc;
    end

    assign o_acc       = r_acc;
    assign o_pipe_busy = r_v1 | r_v2;

endmodule

// File: design/c2ce_seq.sv
// ----------------------------------------------------------------------------
// c2ce_seq
// Request sequencer: geometry, bounds check, kernel walk, result register.
// ----------------------------------------------------------------------------
module c2ce_seq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  c2ce_pkg::t_cfg                      i_cfg,
    input  logic                                i_req,
    input  logic [7:0]                          i_row,
    input  logic [7:0]                          i_col,
    input  logic signed [c2ce_pkg::ACC_W-1:0]   i_acc,
    input  logic                                i_pipe_busy,
    output logic                                o_busy,
    output c2ce_pkg::t_mac_ctl                  o_mac_ctl,
    output logic [c2ce_pkg::FA_W-1:0]           o_frame_addr,
    output logic [c2ce_pkg::CA_W-1:0]           o_coeff_addr,
    output logic                                o_strobe,
    output logic [7:0]                          o_out_row,
    output logic [7:0]                          o_out_col,
    output logic signed [c2ce_pkg::ACC_W-1:0]   o_result,
    output logic                                o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state       r_state, n_state;
    logic [2:0]   r_ky, n_ky;
    logic [2:0]   r_kx, n_kx;
    logic [7:0]   r_row, n_row;
    logic [7:0]   r_col, n_col;
    logic         r_strobe, n_strobe;
    logic         r_status, n_status;
    logic [7:0]   r_out_row, n_out_row;
    logic [7:0]   r_out_col, n_out_col;
    logic signed [c2ce_pkg::ACC_W-1:0] r_result, n_result;

    logic [8:0]         h, w, hm1, wm1;
    logic [2:0]         kh, kw, pt, pl;
    logic signed [10:0] oh, ow;
    logic               outside;
    logic signed [10:0] iy_raw, ix_raw;
    logic [8:0]         iy, ix;

    // effective sizes: zero counts as one, oversize counts as the maximum
    always_comb begin
        h = i_cfg.image_height;
        if (i_cfg.image_height == 9'd0) begin
            h = 9'd1;
        end else if ({4'd0, i_cfg.image_height} > 13'(c2ce_pkg::MAX_HEIGHT)) begin
            h = 9'(c2ce_pkg::MAX_HEIGHT);
        end
        w = i_cfg.image_width;
        if (i_cfg.image_width == 9'd0) begin
            w = 9'd1;
        end else if ({4'd0, i_cfg.image_width} > 13'(c2ce_pkg::MAX_WIDTH)) begin
            w = 9'(c2ce_pkg::MAX_WIDTH);
        end
        kh = i_cfg.kernel_height;
        if (i_cfg.kernel_height == 3'd0) begin
            kh = 3'd1;
        end else if ({1'b0, i_cfg.kernel_height} > 4'(c2ce_pkg::MAX_KERNEL)) begin
            kh = 3'(c2ce_pkg::MAX_KERNEL);
        end
        kw = i_cfg.kernel_width;
        if (i_cfg.kernel_width == 3'd0) begin
            kw = 3'd1;
        end else if ({1'b0, i_cfg.kernel_width} > 4'(c2ce_pkg::MAX_KERNEL)) begin
            kw = 3'(c2ce_pkg::MAX_KERNEL);
        end
        hm1 = h - 9'd1;
        wm1 = w - 9'd1;
        if (i_cfg.same_size) begin
            oh = $signed({2'b00, h});
            ow = $signed({2'b00, w});
            pt = kh >> 1;
            pl = kw >> 1;
        end else begin
            oh = $signed({2'b00, h}) - $signed({8'd0, kh}) + 11'sd1;
            ow = $signed({2'b00, w}) - $signed({8'd0, kw}) + 11'sd1;
            pt = 3'd0;
            pl = 3'd0;
        end
        outside = ($signed({3'b000, i_row}) >= oh) || ($signed({3'b000, i_col}) >= ow);
    end

    // clamp the tap position to the image edge
    always_comb begin
        iy_raw = $signed({3'b000, r_row}) + $signed({8'd0, r_ky}) - $signed({8'd0, pt});
        ix_raw = $signed({3'b000, r_col}) + $signed({8'd0, r_kx}) - $signed({8'd0, pl});
        if (iy_raw < 11'sd0) begin
            iy = 9'd0;
        end else if (iy_raw > $signed({2'b00, hm1})) begin
            iy = hm1;
        end else begin
            iy = iy_raw[8:0];
        end
        if (ix_raw < 11'sd0) begin
            ix = 9'd0;
        end else if (ix_raw > $signed({2'b00, wm1})) begin
            ix = wm1;
        end else begin
            ix = ix_raw[8:0];
        end
    end

    assign o_frame_addr = c2ce_pkg::FA_W'(iy) * c2ce_pkg::FA_W'(c2ce_pkg::MAX_WIDTH)
                        + c2ce_pkg::FA_W'(ix);
    assign o_coeff_addr = c2ce_pkg::CA_W'(r_ky) * c2ce_pkg::CA_W'(c2ce_pkg::MAX_KERNEL)
                        + c2ce_pkg::CA_W'(r_kx);

    always_comb begin
        n_state   = r_state;
        n_ky      = r_ky;
        n_kx      = r_kx;
        n_row     = r_row;
        n_col     = r_col;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_result  = r_result;
        o_mac_ctl = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req) begin
                    n_row = i_row;
                    n_col = i_col;
                    if (outside) begin
                        n_strobe  = 1'b1;
                        n_status  = 1'b1;
                        n_result  = '0;
                        n_out_row = i_row;
                        n_out_col = i_col;
                    end else begin
                        o_mac_ctl.clear = 1'b1;
                        n_ky    = 3'd0;
                        n_kx    = 3'd0;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                o_mac_ctl.issue = 1'b1;
                if (r_kx == kw - 3'd1) begin
                    n_kx = 3'd0;
                    if (r_ky == kh - 3'd1) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_ky = r_ky + 3'd1;
                    end
                end else begin
                    n_kx = r_kx + 3'd1;
                end
            end
            S_DRAIN: begin
                if (!i_pipe_busy) begin
                    n_strobe  = 1'b1;
                    n_status  = 1'b0;
                    n_result  = i_acc;
                    n_out_row = r_row;
                    n_out_col = r_col;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_ky      <= n_ky;
        r_kx      <= n_kx;
        r_row     <= n_row;
        r_col     <= n_col;
        r_status  <= n_status;
        r_out_row <= n_out_row;
        r_out_col <= n_out_col;
        r_result  <= n_result;
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_strobe  = r_strobe;
    assign o_status  = r_status;
    assign o_out_row = r_out_row;
    assign o_out_col = r_out_col;
    assign o_result  = r_result;

endmodule

// File: design/conv2d_clamp_edge_core.sv
// ----------------------------------------------------------------------------
// conv2d_clamp_edge_core
// 2D convolution with clamp-to-edge borders over a stored frame.
//
//   channel   signals                                   handshake
//   -------   ---------------------------------------   -----------------------
//   command   i_op i_row i_col i_pixel_value             start && !busy
//             i_coeff_value
//   result    o_out_row o_out_col o_result o_status      o_strobe, one cycle
//   config    psel penable pwrite paddr pwdata prdata    APB, pready tied high
//
// A load word leaves busy low. A compute word inside the output area holds
// busy while it walks the taps, one tap per cycle through the single
// multiply-accumulate unit and the single read port of each store, then
// drains the read and product registers; the result strobes in the first
// cycle with busy low. A compute word outside the output area strobes in
// the next cycle with busy never raised. Reset is synchronous and resets
// control state and the configuration registers only, not the stores.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
module conv2d_clamp_edge_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_op,
    input  logic [7:0]                          i_row,
    input  logic [7:0]                          i_col,
    input  logic signed [c2ce_pkg::PIX_W-1:0]   i_pixel_value,
    input  logic signed [c2ce_pkg::COEFF_W-1:0] i_coeff_value,
    // result
    output logic                                o_strobe,
    output logic [7:0]                          o_out_row,
    output logic [7:0]                          o_out_col,
    output logic signed [c2ce_pkg::ACC_W-1:0]   o_result,
    output logic                                o_status,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    c2ce_pkg::t_cfg      r_cfg;
    c2ce_pkg::t_mac_ctl  mac_ctl;

    logic        accept;
    logic        cfg_wr;
    logic [2:0]  reg_idx;
    logic        frame_we;
    logic        coeff_we;
    logic [c2ce_pkg::FA_W-1:0] frame_waddr;
    logic [c2ce_pkg::CA_W-1:0] coeff_waddr;
    logic [c2ce_pkg::FA_W-1:0] frame_raddr;
    logic [c2ce_pkg::CA_W-1:0] coeff_raddr;
    logic signed [c2ce_pkg::PIX_W-1:0]   rd_pixel;
    logic signed [c2ce_pkg::COEFF_W-1:0] rd_coeff;
    logic signed [c2ce_pkg::ACC_W-1:0]   acc;
    logic        pipe_busy;

    // accept a command word only while the sequencer is idle
    assign accept = start && !busy;

    // -------------------------------------------------------------------------
    // Configuration registers
    // -------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_height  <= 9'd256;
            r_cfg.image_width   <= 9'd256;
            r_cfg.kernel_height <= 3'd3;
            r_cfg.kernel_width  <= 3'd3;
            r_cfg.same_size     <= 1'b1;
        end else if (cfg_wr) begin
            case (reg_idx)
                c2ce_pkg::REG_IMAGE_HEIGHT:  r_cfg.image_height  <= pwdata[8:0];
                c2ce_pkg::REG_IMAGE_WIDTH:   r_cfg.image_width   <= pwdata[8:0];
                c2ce_pkg::REG_KERNEL_HEIGHT: r_cfg.kernel_height <= pwdata[2:0];
                c2ce_pkg::REG_KERNEL_WIDTH:  r_cfg.kernel_width  <= pwdata[2:0];
                c2ce_pkg::REG_SAME_SIZE:     r_cfg.same_size     <= pwdata[0];
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            c2ce_pkg::REG_IMAGE_HEIGHT:  prdata = {23'd0, r_cfg.image_height};
            c2ce_pkg::REG_IMAGE_WIDTH:   prdata = {23'd0, r_cfg.image_width};
            c2ce_pkg::REG_KERNEL_HEIGHT: prdata = {29'd0, r_cfg.kernel_height};
            c2ce_pkg::REG_KERNEL_WIDTH:  prdata = {29'd0, r_cfg.kernel_width};
            c2ce_pkg::REG_SAME_SIZE:     prdata = {31'd0, r_cfg.same_size};
            default:                     prdata = 32'd0;
        endcase
    end

    // -------------------------------------------------------------------------
    // Load decode: drop loads that fall outside the stores
    // -------------------------------------------------------------------------
    assign frame_we = accept && (i_op == c2ce_pkg::OP_LOAD_PIXEL)
                   && ({5'd0, i_row} < 13'(c2ce_pkg::MAX_HEIGHT))
                   && ({5'd0, i_col} < 13'(c2ce_pkg::MAX_WIDTH));
    assign coeff_we = accept && (i_op == c2ce_pkg::OP_LOAD_COEFF)
                   && ({1'b0, i_row} < 9'(c2ce_pkg::MAX_KERNEL))
                   && ({1'b0, i_col} < 9'(c2ce_pkg::MAX_KERNEL));

    assign frame_waddr = c2ce_pkg::FA_W'(i_row) * c2ce_pkg::FA_W'(c2ce_pkg::MAX_WIDTH)
                       + c2ce_pkg::FA_W'(i_col);
    assign coeff_waddr = c2ce_pkg::CA_W'(i_row) * c2ce_pkg::CA_W'(c2ce_pkg::MAX_KERNEL)
                       + c2ce_pkg::CA_W'(i_col);

    // -------------------------------------------------------------------------
    // Datapath
    // -------------------------------------------------------------------------
    c2ce_store u_store (
        .i_clk         (i_clk),
        .i_frame_we    (frame_we),
        .i_frame_waddr (frame_waddr),
        .i_frame_wdata (i_pixel_value),
        .i_coeff_we    (coeff_we),
        .i_coeff_waddr (coeff_waddr),
        .i_coeff_wdata (i_coeff_value),
        .i_rd_en       (mac_ctl.issue),
        .i_frame_raddr (frame_raddr),
        .i_coeff_raddr (coeff_raddr),
        .o_pixel       (rd_pixel),
        .o_coeff       (rd_coeff)
    );

    c2ce_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mac_ctl),
        .i_pixel     (rd_pixel),
        .i_coeff     (rd_coeff),
        .o_acc       (acc),
        .o_pipe_busy (pipe_busy)
    );

    // walk the kernel taps and strobe each result word for one cycle
    c2ce_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_req        (accept && (i_op == c2ce_pkg::OP_COMPUTE)),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_acc        (acc),
        .i_pipe_busy  (pipe_busy),
        .o_busy       (busy),
        .o_mac_ctl    (mac_ctl),
        .o_frame_addr (frame_raddr),
        .o_coeff_addr (coeff_raddr),
        .o_strobe     (o_strobe),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_result     (o_result),
        .o_status     (o_status)
    );

endmodule

// File: design/c2ce_checker.sv
// ----------------------------------------------------------------------------
// c2ce_checker
// Port-level timing checks of the convolution core, bound to the top level.
// ----------------------------------------------------------------------------
`include "conv2d_clamp_edge_core_macros.svh"

module c2ce_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [1:0]                          i_op,
    input logic                                o_strobe,
    input logic signed [c2ce_pkg::ACC_W-1:0]   o_result,
    input logic                                o_status
);

    // a result word is only shown once the sequencer is idle again
    `C2CE_ASSERT_NOW(a_strobe_idle, o_strobe, !busy)

    // a compute word either starts the kernel walk or answers at once
    `C2CE_ASSERT_NEXT(a_compute_reacts, start && !busy && (i_op == c2ce_pkg::OP_COMPUTE),
        o_strobe || busy)

    // a load word or an unused opcode gives no result and does not raise busy
    `C2CE_ASSERT_NEXT(a_load_silent, start && !busy && (i_op != c2ce_pkg::OP_COMPUTE),
        !o_strobe && !busy)

    // an out-of-area answer carries a zero sum
    `C2CE_ASSERT_NOW(a_error_zero, o_strobe && o_status, o_result == '0)

    // the end of a kernel walk always delivers its word
    `C2CE_ASSERT_NOW(a_walk_delivers, $fell(busy) && $past(i_rst_n), o_strobe)

endmodule

bind conv2d_clamp_edge_core c2ce_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_op     (i_op),
    .o_strobe (o_strobe),
    .o_result (o_result),
    .o_status (o_status)
);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for conv2d_clamp_edge_core. A queue of command words
// feeds a clocked driver; a clocked monitor runs an in-bench convolution
// predictor on every accepted word and checks each strobed result in order.
// The run steps through several register settings: the reset values, single
// pixel images, kernels wider than the image, empty valid-mode outputs and
// out-of-range register values. Each phase holds well-formed requests
// whose kernel and image windows are loaded first, mixed with stray loads,
// ignored loads, unused opcodes and requests outside the output area.
// ----------------------------------------------------------------------------
module tb_top;
    import c2ce_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Let in-flight work finish before touching registers: one full kernel
    // of taps plus the drain stages, with margin.
    localparam int DRAIN_CYCLES   = MAX_KERNEL * MAX_KERNEL + 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PERCENT   = 8;
    localparam int ITEM_TARGET    = 1150;
    // Accepted-word window in which the driver never idles at random.
    localparam int STEADY_FIRST   = 300;
    localparam int STEADY_LAST    = 520;

    localparam logic signed [PIX_W-1:0]   PIX_MAX   = 16'sh7FFF;
    localparam logic signed [PIX_W-1:0]   PIX_MIN   = 16'sh8000;
    localparam logic signed [COEFF_W-1:0] COEFF_MAX = 18'sh1FFFF;
    localparam logic signed [COEFF_W-1:0] COEFF_MIN = 18'sh20000;

    typedef struct packed {
        logic [1:0]                 op;
        logic [7:0]                 row;
        logic [7:0]                 col;
        logic signed [PIX_W-1:0]    pix;
        logic signed [COEFF_W-1:0]  coeff;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0]                 row;
        logic [7:0]                 col;
        logic signed [ACC_W-1:0]    sum;
        logic                       status;
    } pixel_out_t;

    // Effective geometry after the register values are brought into range.
    typedef struct {
        int h;
        int w;
        int kh;
        int kw;
        int oh;
        int ow;
        int pt;
        int pl;
    } geom_t;

    // ------------------------------------------------------------------
    // DUT signals, inputs known from time zero
    // ------------------------------------------------------------------
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [1:0]                 i_op = OP_LOAD_COEFF;
    logic [7:0]                 i_row = '0;
    logic [7:0]                 i_col = '0;
    logic signed [PIX_W-1:0]    i_pixel_value = '0;
    logic signed [COEFF_W-1:0]  i_coeff_value = '0;
    logic                       o_strobe;
    logic [7:0]                 o_out_row;
    logic [7:0]                 o_out_col;
    logic signed [ACC_W-1:0]    o_result;
    logic                       o_status;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [4:0]                 paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    conv2d_clamp_edge_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_pixel_value (i_pixel_value),
        .i_coeff_value (i_coeff_value),
        .o_strobe      (o_strobe),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_result      (o_result),
        .o_status      (o_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    // Predictor copy of the stores and the register settings.
    logic signed [PIX_W-1:0]    frame_img [FRAME_DEPTH];
    logic signed [COEFF_W-1:0]  coeff_img [COEFF_DEPTH];
    t_cfg                       cfg;

    // Which entries the queued words will have written by the time each
    // queued request runs; requests never touch an entry left unwritten.
    bit                         pix_seen [FRAME_DEPTH];
    bit                         coef_seen [COEFF_DEPTH];

    cmd_word_t                  pending_words [$];
    pixel_out_t                 expected_pixels [$];
    cmd_word_t                  live_word;
    cmd_word_t                  taken_word;
    logic                       taken = 1'b0;
    int                         queued_items = 0;
    int                         words_sent = 0;
    int                         quiet_cycles = 0;
    int                         fail_count = 0;

    // ------------------------------------------------------------------
    // Geometry and predictor
    // ------------------------------------------------------------------
    function automatic int fit(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int clamp_to(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic geom_t shape_of(t_cfg c);
        geom_t g;
        g.h  = fit(int'(c.image_height), MAX_HEIGHT);
        g.w  = fit(int'(c.image_width), MAX_WIDTH);
        g.kh = fit(int'(c.kernel_height), MAX_KERNEL);
        g.kw = fit(int'(c.kernel_width), MAX_KERNEL);
        if (c.same_size) begin
            g.oh = g.h;
            g.ow = g.w;
            g.pt = g.kh / 2;
            g.pl = g.kw / 2;
        end else begin
            // valid mode: may leave an empty output area
            g.oh = g.h - g.kh + 1;
            g.ow = g.w - g.kw + 1;
            g.pt = 0;
            g.pl = 0;
        end
        return g;
    endfunction

    function automatic bit in_area(geom_t g, int r, int c);
        return (r < g.oh) && (c < g.ow);
    endfunction

    // Apply one accepted word to the predictor; return 1 when it yields a
    // result word, which is placed in res.
    function automatic bit convolve_word(cmd_word_t w, output pixel_out_t res);
        geom_t  g;
        longint acc;
        int     iy;
        int     ix;
        res = '0;
        acc = 0;
        case (w.op)
            OP_LOAD_COEFF: begin
                // out-of-range kernel positions are dropped
                if (w.row < MAX_KERNEL && w.col < MAX_KERNEL)
                    coeff_img[w.row * MAX_KERNEL + w.col] = w.coeff;
                return 1'b0;
            end
            OP_LOAD_PIXEL: begin
                if (w.row < MAX_HEIGHT && w.col < MAX_WIDTH)
                    frame_img[w.row * MAX_WIDTH + w.col] = w.pix;
                return 1'b0;
            end
            OP_COMPUTE: begin
                g = shape_of(cfg);
                res.row = w.row;
                res.col = w.col;
                if (!in_area(g, int'(w.row), int'(w.col))) begin
                    res.sum    = '0;
                    res.status = 1'b1;
                    return 1'b1;
                end
                for (int ky = 0; ky < g.kh; ky++) begin
                    iy = clamp_to(int'(w.row) + ky - g.pt, g.h - 1);
                    for (int kx = 0; kx < g.kw; kx++) begin
                        ix = clamp_to(int'(w.col) + kx - g.pl, g.w - 1);
                        acc += longint'(frame_img[iy * MAX_WIDTH + ix]) *
                               longint'(coeff_img[ky * MAX_KERNEL + kx]);
                    end
                end
                res.sum    = acc[ACC_W-1:0];
                res.status = 1'b0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic logic signed [PIX_W-1:0] rand_pix();
        logic [31:0] r;
        r = $urandom;
        return r[PIX_W-1:0];
    endfunction

    function automatic logic signed [COEFF_W-1:0] rand_coeff();
        logic [31:0] r;
        r = $urandom;
        return r[COEFF_W-1:0];
    endfunction

    // Queue one word and track which store entries it writes. Words the
    // block merely ignores do not count toward the item total.
    function automatic void queue_word(logic [1:0] op, logic [7:0] row, logic [7:0] col,
                                       logic signed [PIX_W-1:0] pix,
                                       logic signed [COEFF_W-1:0] coeff);
        cmd_word_t w;
        w.op    = op;
        w.row   = row;
        w.col   = col;
        w.pix   = pix;
        w.coeff = coeff;
        pending_words.push_back(w);
        case (op)
            OP_LOAD_COEFF: begin
                if (row < MAX_KERNEL && col < MAX_KERNEL) begin
                    coef_seen[row * MAX_KERNEL + col] = 1'b1;
                    queued_items++;
                end
            end
            OP_LOAD_PIXEL: begin
                if (row < MAX_HEIGHT && col < MAX_WIDTH) begin
                    pix_seen[row * MAX_WIDTH + col] = 1'b1;
                    queued_items++;
                end
            end
            OP_COMPUTE: queued_items++;
            default: ;
        endcase
    endfunction

    // Queue a request; when it lands inside the output area, first load
    // every coefficient and clamped pixel of its window not yet written.
    function automatic void queue_request(int r, int c);
        geom_t g;
        int    iy;
        int    ix;
        g = shape_of(cfg);
        if (in_area(g, r, c)) begin
            for (int ky = 0; ky < g.kh; ky++) begin
                iy = clamp_to(r + ky - g.pt, g.h - 1);
                for (int kx = 0; kx < g.kw; kx++) begin
                    ix = clamp_to(c + kx - g.pl, g.w - 1);
                    if (!coef_seen[ky * MAX_KERNEL + kx])
                        queue_word(OP_LOAD_COEFF, 8'(ky), 8'(kx), rand_pix(), rand_coeff());
                    if (!pix_seen[iy * MAX_WIDTH + ix])
                        queue_word(OP_LOAD_PIXEL, 8'(iy), 8'(ix), rand_pix(), rand_coeff());
                end
            end
        end
        queue_word(OP_COMPUTE, 8'(r), 8'(c), rand_pix(), rand_coeff());
    endfunction

    // Favor the borders, where clamping bites, and a small corner patch so
    // that windows overlap and reuse loaded pixels.
    function automatic int pick_coord(int n);
        case ($urandom_range(3))
            0:       return 0;
            1:       return n - 1;
            2:       return $urandom_range(n - 1);
            default: return $urandom_range(((n < 6) ? n : 6) - 1);
        endcase
    endfunction

    // Random traffic for one phase: well-formed or random requests, the rest
    // stray loads, ignored loads, unused opcodes and out-of-area requests.
    function automatic void fill_phase(int n);
        geom_t g;
        int    stop;
        int    sel;
        g = shape_of(cfg);
        stop = queued_items + n;
        while (queued_items < stop) begin
            sel = $urandom_range(19);
            if (sel < 9) begin
                if (g.oh > 0 && g.ow > 0)
                    queue_request(pick_coord(g.oh), pick_coord(g.ow));
                else
                    queue_request($urandom_range(255), $urandom_range(255));
            end else if (sel < 11) begin
                queue_request($urandom_range(255), $urandom_range(255));
            end else if (sel < 13) begin
                // outside the output area wherever the area leaves room
                if (g.oh < 1 || g.ow < 1)
                    queue_request($urandom_range(255), $urandom_range(255));
                else if (g.oh < 256 && $urandom_range(1) == 0)
                    queue_request($urandom_range(255, g.oh), $urandom_range(255));
                else if (g.ow < 256)
                    queue_request($urandom_range(255), $urandom_range(255, g.ow));
                else
                    queue_request(pick_coord(g.oh), pick_coord(g.ow));
            end else if (sel < 15) begin
                queue_word(OP_LOAD_COEFF, 8'($urandom_range(MAX_KERNEL - 1)),
                           8'($urandom_range(MAX_KERNEL - 1)), rand_pix(), rand_coeff());
            end else if (sel < 17) begin
                queue_word(OP_LOAD_PIXEL, 8'($urandom_range(g.h - 1)),
                           8'($urandom_range(g.w - 1)), rand_pix(), rand_coeff());
            end else if (sel == 17) begin
                queue_word(OP_LOAD_COEFF, 8'($urandom_range(255)), 8'($urandom_range(255)),
                           rand_pix(), rand_coeff());
            end else if (sel == 18) begin
                queue_word(OP_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)),
                           rand_pix(), rand_coeff());
            end else begin
                // anywhere in the store, regardless of the image size
                queue_word(OP_LOAD_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                           rand_pix(), rand_coeff());
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    // Setup cycle, then access cycle; the register takes the value at the
    // edge that closes the access cycle. Bits above the field are sometimes
    // filled with junk, which the block must drop.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value, logic [31:0] mask);
        logic [31:0] data;
        data = value & mask;
        if ($urandom_range(2) == 0)
            data = data | ($urandom & ~mask);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(int h, int w, int kh, int kw, int ss);
        write_reg(REG_IMAGE_HEIGHT, 32'(h), 32'h1FF);
        write_reg(REG_IMAGE_WIDTH, 32'(w), 32'h1FF);
        write_reg(REG_KERNEL_HEIGHT, 32'(kh), 32'h7);
        write_reg(REG_KERNEL_WIDTH, 32'(kw), 32'h7);
        write_reg(REG_SAME_SIZE, 32'(ss), 32'h1);
        cfg.image_height  = h[8:0];
        cfg.image_width   = w[8:0];
        cfg.kernel_height = kh[2:0];
        cfg.kernel_width  = kw[2:0];
        cfg.same_size     = ss[0];
    endtask

    // Hold until every queued word is accepted and every result is back,
    // then let the block settle.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || start || taken || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: present the next word from the queue, hold it while busy,
    // and idle at random outside the steady window.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cmd_word_t nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
            taken <= 1'b0;
        end else begin
            taken <= start && !busy;
            if (start && !busy) begin
                taken_word <= live_word;
                words_sent++;
            end
            // a free slot: either nothing was up, or the word just went in
            if (!start || !busy) begin
                if (pending_words.size() != 0 &&
                    !((words_sent < STEADY_FIRST || words_sent >= STEADY_LAST) &&
                      $urandom_range(99) < IDLE_PERCENT)) begin
                    nxt = pending_words.pop_front();
                    live_word     <= nxt;
                    start         <= 1'b1;
                    i_op          <= nxt.op;
                    i_row         <= nxt.row;
                    i_col         <= nxt.col;
                    i_pixel_value <= nxt.pix;
                    i_coeff_value <= nxt.coeff;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict the word accepted at the previous edge, then check
    // any strobed result against the oldest expectation. A result can
    // strobe no sooner than the edge at which the monitor sees it taken, so predicting
    // first keeps the order fixed within the block.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        pixel_out_t fresh;
        pixel_out_t want;
        if (i_rst_n) begin
            if (taken) begin
                if (convolve_word(taken_word, fresh))
                    expected_pixels.push_back(fresh);
            end
            if (o_strobe) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result word: row %0d col %0d result %0d status %0d",
                           o_out_row, o_out_col, o_result, o_status);
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_out_row !== want.row) begin
                        $error("out_row: expected %0d, got %0d", want.row, o_out_row);
                        fail_count++;
                    end
                    if (o_out_col !== want.col) begin
                        $error("out_col: expected %0d, got %0d", want.col, o_out_col);
                        fail_count++;
                    end
                    if (o_result !== want.sum) begin
                        $error("result: expected %0d, got %0d", want.sum, o_result);
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                end
            end
            // watchdog: count cycles in which nothing moves on any port
            if (taken || o_strobe || psel) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("tb_top: FAIL");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial begin
        cfg.image_height  = 9'd256;
        cfg.image_width   = 9'd256;
        cfg.kernel_height = 3'd3;
        cfg.kernel_width  = 3'd3;
        cfg.same_size     = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: field extremes, dropped kernel loads, the unused
        // opcode, and requests at the far corners of a full-size frame.
        queue_word(OP_LOAD_COEFF, 8'd0, 8'd0, rand_pix(), COEFF_MAX);
        queue_word(OP_LOAD_COEFF, 8'd6, 8'd6, rand_pix(), COEFF_MIN);
        queue_word(OP_LOAD_COEFF, 8'd7, 8'd0, PIX_MIN, COEFF_MAX);
        queue_word(OP_LOAD_COEFF, 8'd0, 8'd255, PIX_MAX, COEFF_MIN);
        queue_word(OP_LOAD_PIXEL, 8'd0, 8'd0, PIX_MAX, rand_coeff());
        queue_word(OP_LOAD_PIXEL, 8'd255, 8'd255, PIX_MIN, rand_coeff());
        queue_word(OP_LOAD_PIXEL, 8'd0, 8'd255, PIX_MIN, rand_coeff());
        queue_word(OP_LOAD_PIXEL, 8'd255, 8'd0, PIX_MAX, rand_coeff());
        queue_word(OP_UNUSED, 8'hFF, 8'hFF, PIX_MIN, COEFF_MIN);
        queue_request(0, 0);
        queue_request(255, 255);
        fill_phase(150);
        drain();

        // single-pixel image, 1x1 kernel: largest product, then off-area
        set_config(1, 1, 1, 1, 1);
        queue_word(OP_LOAD_COEFF, 8'd0, 8'd0, rand_pix(), COEFF_MIN);
        queue_word(OP_LOAD_PIXEL, 8'd0, 8'd0, PIX_MIN, rand_coeff());
        queue_request(0, 0);
        queue_request(0, 1);
        queue_request(1, 0);
        fill_phase(60);
        drain();

        // kernel larger than the image: heavy clamping in same mode
        set_config(4, 5, 7, 7, 1);
        fill_phase(80);
        drain();

        // same sizes in valid mode: the output area is empty
        set_config(4, 5, 7, 7, 0);
        fill_phase(40);
        drain();

        // out-of-range values: zero height and kernel height, width too large
        set_config(0, 511, 0, 7, 0);
        fill_phase(80);
        drain();

        set_config(256, 256, 7, 7, 0);
        fill_phase(120);
        drain();

        set_config(8, 6, 3, 5, 0);
        fill_phase(80);
        drain();

        // even kernel sizes and a zero kernel width in same mode
        set_config(7, 9, 2, 4, 1);
        fill_phase(60);
        drain();

        set_config(5, 3, 6, 0, 1);
        fill_phase(60);
        drain();

        // random settings, small images most of the time
        while (queued_items < ITEM_TARGET) begin
            set_config(($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(16),
                       ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(16),
                       $urandom_range(7), $urandom_range(7), $urandom_range(1));
            fill_phase(80);
            drain();
        end

        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: conv2d_clamp_edge_core.f
+incdir+design
design/c2ce_pkg.sv
design/c2ce_store.sv
design/c2ce_mac.sv
design/c2ce_seq.sv
design/conv2d_clamp_edge_core.sv
design/c2ce_checker.sv
test/tb_top.sv
